// ----- hw/rtl/fen_position_parser_defines.svh -----
// Assertion macros shared by the FEN parser RTL.
// Each macro expects clk and rst_n in scope.
`ifndef FEN_POSITION_PARSER_DEFINES_SVH
`define FEN_POSITION_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fpp_pkg.sv -----
package fpp_pkg;

    // Board geometry
    localparam int unsigned BOARD_FILES = 8;
    localparam int unsigned BOARD_RANKS = 8;

    // Token index within the FEN string
    localparam logic [2:0] FIELD_PLACE  = 3'd0;
    localparam logic [2:0] FIELD_SIDE   = 3'd1;
    localparam logic [2:0] FIELD_CASTLE = 3'd2;
    localparam logic [2:0] FIELD_EP     = 3'd3;
    localparam logic [2:0] FIELD_HALF   = 3'd4;
    localparam logic [2:0] FIELD_FULL   = 3'd5;
    localparam logic [2:0] FIELD_EXTRA  = 3'd6;

    // Error codes reported in the summary
    localparam logic [3:0] ERR_NONE    = 4'd0;
    localparam logic [3:0] ERR_MISSING = 4'd1;
    localparam logic [3:0] ERR_RANKS   = 4'd2;
    localparam logic [3:0] ERR_WIDE    = 4'd3;
    localparam logic [3:0] ERR_PIECE   = 4'd4;
    localparam logic [3:0] ERR_SIDE    = 4'd5;
    localparam logic [3:0] ERR_CASTLE  = 4'd6;
    localparam logic [3:0] ERR_EP      = 4'd7;
    localparam logic [3:0] ERR_CLOCK   = 4'd8;

    // Result kinds
    localparam logic KIND_PLACE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_UK    = 8'h4B;
    localparam logic [7:0] CH_UQ    = 8'h51;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_K     = 8'h6B;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Piece kinds
    localparam logic [2:0] PIECE_PAWN   = 3'd0;
    localparam logic [2:0] PIECE_KNIGHT = 3'd1;
    localparam logic [2:0] PIECE_BISHOP = 3'd2;
    localparam logic [2:0] PIECE_ROOK   = 3'd3;
    localparam logic [2:0] PIECE_QUEEN  = 3'd4;
    localparam logic [2:0] PIECE_KING   = 3'd5;

    localparam logic [3:0] ROW_SAT  = 4'd15;
    localparam logic [2:0] LEN_SAT  = 3'd7;
    localparam logic [3:0] LAST_ROW = 4'(BOARD_RANKS - 1);
    localparam logic [3:0] ROW_LIM  = 4'(BOARD_RANKS);
    localparam logic [3:0] FILE_LIM = 4'(BOARD_FILES);

    // Parser state apart from the halfmove and fullmove counters
    typedef struct packed {
        logic [2:0] field_index;
        logic [3:0] row_count;
        logic [3:0] file_pos;
        logic [2:0] token_len;
        logic       side;
        logic [3:0] castle;
        logic [6:0] ep;       // bit 6 valid, low bits square or pending file
        logic [3:0] error;
        logic       dash;
    } state_t;

    typedef struct packed {
        logic        kind;
        logic [5:0]  square_index;
        logic        color;
        logic [2:0]  piece_kind;
        logic        side;
        logic [3:0]  castling;
        logic        ep_valid;
        logic [5:0]  ep_square;
        logic [15:0] halfmove;
        logic [15:0] fullmove;
        logic [3:0]  error_code;
    } result_t;

    // Map a lowercase letter to {valid, piece kind}
    function automatic logic [3:0] piece_of(input logic [7:0] lower);
        logic [3:0] r;
        begin
            case (lower)
                CH_P:    r = {1'b1, PIECE_PAWN};
                CH_N:    r = {1'b1, PIECE_KNIGHT};
                CH_B:    r = {1'b1, PIECE_BISHOP};
                CH_R:    r = {1'b1, PIECE_ROOK};
                CH_Q:    r = {1'b1, PIECE_QUEEN};
                CH_K:    r = {1'b1, PIECE_KING};
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

    // Close the current token
    function automatic state_t finish_token(input state_t s);
        state_t n;
        begin
            n = s;
            if (s.field_index == FIELD_EP && s.token_len == 3'd1 && !s.dash
                && n.error == ERR_NONE)
            begin
                n.error = ERR_EP;
            end
            n.token_len = 3'd0;
            n.dash      = 1'b0;
            if (s.field_index < FIELD_EXTRA)
            begin
                n.field_index = s.field_index + 3'd1;
            end
            return n;
        end
    endfunction

endpackage

// ----- hw/rtl/fen_position_parser.sv -----
// FEN position parser. Feed the FEN text one ASCII character per beat on the
// slave side, with tlast on the final character. Each piece letter that lands
// on a board square, except one on the final character, yields a placement
// beat (tuser 0); the final character yields a summary beat (tuser 1) with
// side to move, castling rights, en passant square, both move clocks
// (saturating) and an error code, after which the parser is back in its reset
// state for the next string. The block takes one character every cycle while
// the result register is not stalled: a character goes through an input
// register and then a result register, from which any result it yields is
// offered on the master side. The parser state updates once per accepted
// character, and only a stalled result register holds the input side back.
`include "fen_position_parser_defines.svh"

module fen_position_parser
    import fpp_pkg::*;
#(
    parameter int unsigned CLOCK_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // square_index[5:0], color[6], piece_kind[9:7],
                                   // side[10], castling[14:11], ep_valid[15],
                                   // ep_square[21:16], halfmove[37:22],
                                   // fullmove[53:38], error_code[57:54], zero pad
    output logic        m_tuser    // kind
);

    logic                  in_valid_reg;
    logic [7:0]            ch_reg;
    logic                  last_reg;
    state_t                state_reg;
    state_t                state_next;
    logic [CLOCK_BITS-1:0] half_reg;
    logic [CLOCK_BITS-1:0] half_next;
    logic [CLOCK_BITS-1:0] full_reg;
    logic [CLOCK_BITS-1:0] full_next;
    logic                  out_valid_reg;
    result_t               out_reg;
    result_t               res;
    logic                  emit;
    logic                  advance;

    // Step when the result register can take whatever comes out
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    fpp_step #(
        .CLOCK_BITS(CLOCK_BITS)
    ) u_step (
        .st        (state_reg),
        .half      (half_reg),
        .full      (full_reg),
        .ch        (ch_reg),
        .last      (last_reg),
        .st_next   (state_next),
        .half_next (half_next),
        .full_next (full_next),
        .emit      (emit),
        .res       (res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            ch_reg   <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            half_reg  <= '0;
            full_reg  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            half_reg  <= half_next;
            full_reg  <= full_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {6'd0, out_reg.error_code, out_reg.fullmove, out_reg.halfmove,
                       out_reg.ep_square, out_reg.ep_valid, out_reg.castling,
                       out_reg.side, out_reg.piece_kind, out_reg.color,
                       out_reg.square_index};

    // Checks
    `FPP_ASSERT_NEXT(a_summary_resets, advance && last_reg,
        state_reg.field_index == FIELD_PLACE && state_reg.error == ERR_NONE,
        "parser state not cleared after summary")
    `FPP_ASSERT_NOW(a_file_in_range, 1'b1, state_reg.file_pos <= FILE_LIM,
        "file position beyond board")
    `FPP_ASSERT_NOW(a_placement_clean, m_tvalid && m_tuser == KIND_PLACE,
        m_tdata[57:10] == 48'd0, "placement beat carries summary fields")
    `FPP_ASSERT_NEXT(a_stall_holds, in_valid_reg && !advance,
        in_valid_reg && $stable(ch_reg) && $stable(last_reg),
        "input register lost a stalled character")

endmodule

// ----- hw/rtl/fpp_step.sv -----
module fpp_step
    import fpp_pkg::*;
#(
    parameter int unsigned CLOCK_BITS = 16
) (
    input  state_t                st,
    input  logic [CLOCK_BITS-1:0] half,
    input  logic [CLOCK_BITS-1:0] full,
    input  logic [7:0]            ch,
    input  logic                  last,
    output state_t                st_next,
    output logic [CLOCK_BITS-1:0] half_next,
    output logic [CLOCK_BITS-1:0] full_next,
    output logic                  emit,
    output result_t               res
);

    localparam int unsigned WIDE = CLOCK_BITS + 4;

    logic                  is_space;
    logic                  upper;
    logic [7:0]            lower;
    logic [3:0]            piece;
    logic [4:0]            file_sum;
    logic [7:0]            ch_ofs;
    logic [3:0]            final_err;
    logic [15:0]           half16;
    logic [15:0]           full16;
    logic [CLOCK_BITS-1:0] clk_in;
    logic [CLOCK_BITS-1:0] clk_upd;
    logic [WIDE-1:0]       clk_wide;
    logic                  clk_digit;
    logic [CLOCK_BITS-1:0] half_acc;
    logic [CLOCK_BITS-1:0] full_acc;

    // Times ten plus digit, saturating at the counter width
    always_comb
    begin
        clk_in   = (st.field_index == FIELD_HALF) ? half : full;
        clk_wide = ({4'd0, clk_in} << 3) + ({4'd0, clk_in} << 1)
                 + {{CLOCK_BITS{1'b0}}, ch[3:0]};
        clk_upd  = (|clk_wide[WIDE-1:CLOCK_BITS]) ? {CLOCK_BITS{1'b1}}
                                                  : clk_wide[CLOCK_BITS-1:0];
        // Clocks after this character, before any end-of-string clear
        clk_digit = (ch inside {[CH_0:CH_9]}) && !st.dash
                  && (st.field_index == FIELD_HALF || st.field_index == FIELD_FULL);
        half_acc  = (clk_digit && st.field_index == FIELD_HALF) ? clk_upd : half;
        full_acc  = (clk_digit && st.field_index == FIELD_FULL) ? clk_upd : full;
    end

    // Clamp the clocks to the 16-bit result fields, or zero-extend narrower ones
    if (CLOCK_BITS > 16)
    begin : g_clamp
        assign half16 = (|half_acc[CLOCK_BITS-1:16]) ? 16'hFFFF : half_acc[15:0];
        assign full16 = (|full_acc[CLOCK_BITS-1:16]) ? 16'hFFFF : full_acc[15:0];
    end
    else
    begin : g_extend
        assign half16 = 16'(half_acc);
        assign full16 = 16'(full_acc);
    end

    // Advance the parser by one character
    always_comb
    begin
        st_next   = st;
        half_next = half;
        full_next = full;
        emit      = 1'b0;
        res       = '0;
        final_err = ERR_NONE;
        is_space  = (ch == CH_SPACE) || (ch inside {[CH_TAB:CH_CR]});
        upper     = ch inside {[CH_UA:CH_UZ]};
        lower     = upper ? ch + CASE_OFS : ch;
        piece     = piece_of(lower);
        file_sum  = {1'b0, st.file_pos} + {1'b0, ch[3:0]};
        ch_ofs    = ch - CH_A;

        if (is_space)
        begin
            if (st.token_len != 3'd0)
            begin
                st_next = finish_token(st);
            end
        end
        else
        begin
            case (st.field_index)
                FIELD_PLACE:
                begin
                    if (ch == CH_SLASH)
                    begin
                        if (st.row_count < ROW_SAT)
                        begin
                            st_next.row_count = st.row_count + 4'd1;
                        end
                        st_next.file_pos = 4'd0;
                    end
                    else if (ch inside {[CH_0:CH_9]})
                    begin
                        if (file_sum > {1'b0, FILE_LIM})
                        begin
                            if (st.error == ERR_NONE) st_next.error = ERR_WIDE;
                        end
                        else
                        begin
                            st_next.file_pos = file_sum[3:0];
                        end
                    end
                    else if (!piece[3])
                    begin
                        if (st.error == ERR_NONE) st_next.error = ERR_PIECE;
                    end
                    else if (st.file_pos >= FILE_LIM)
                    begin
                        if (st.error == ERR_NONE) st_next.error = ERR_WIDE;
                    end
                    else
                    begin
                        st_next.file_pos = st.file_pos + 4'd1;
                        if (st.row_count < ROW_LIM && !last)
                        begin
                            emit             = 1'b1;
                            res.kind         = KIND_PLACE;
                            res.square_index = {3'(LAST_ROW - st.row_count),
                                                st.file_pos[2:0]};
                            res.color        = !upper;
                            res.piece_kind   = piece[2:0];
                        end
                    end
                end
                FIELD_SIDE:
                begin
                    if (st.token_len == 3'd0 && ch == CH_W)
                    begin
                        st_next.side = 1'b0;
                    end
                    else if (st.token_len == 3'd0 && ch == CH_B)
                    begin
                        st_next.side = 1'b1;
                    end
                    else if (st.error == ERR_NONE)
                    begin
                        st_next.error = ERR_SIDE;
                    end
                end
                FIELD_CASTLE:
                begin
                    if (ch == CH_DASH)
                    begin
                        if (st.token_len != 3'd0)
                        begin
                            if (st.error == ERR_NONE) st_next.error = ERR_CASTLE;
                        end
                        else
                        begin
                            st_next.dash = 1'b1;
                        end
                    end
                    else if (ch inside {CH_UK, CH_UQ, CH_K, CH_Q})
                    begin
                        if (st.dash)
                        begin
                            if (st.error == ERR_NONE) st_next.error = ERR_CASTLE;
                        end
                        else
                        begin
                            st_next.castle[0] = st.castle[0] | (ch == CH_UK);
                            st_next.castle[1] = st.castle[1] | (ch == CH_UQ);
                            st_next.castle[2] = st.castle[2] | (ch == CH_K);
                            st_next.castle[3] = st.castle[3] | (ch == CH_Q);
                        end
                    end
                    else if (st.error == ERR_NONE)
                    begin
                        st_next.error = ERR_CASTLE;
                    end
                end
                FIELD_EP:
                begin
                    if (st.token_len == 3'd0)
                    begin
                        if (ch == CH_DASH)
                        begin
                            st_next.dash = 1'b1;
                        end
                        else if (ch inside {[CH_A:CH_H]})
                        begin
                            st_next.ep = {4'd0, ch_ofs[2:0]};
                        end
                        else if (st.error == ERR_NONE)
                        begin
                            st_next.error = ERR_EP;
                        end
                    end
                    else if (st.token_len == 3'd1 && !st.dash
                             && (ch inside {[CH_1:CH_8]}))
                    begin
                        st_next.ep = {1'b1, 3'(ch - CH_1), st.ep[2:0]};
                    end
                    else if (st.error == ERR_NONE)
                    begin
                        st_next.error = ERR_EP;
                    end
                end
                FIELD_HALF, FIELD_FULL:
                begin
                    if (ch == CH_DASH)
                    begin
                        if (st.token_len != 3'd0)
                        begin
                            if (st.error == ERR_NONE) st_next.error = ERR_CLOCK;
                        end
                        else
                        begin
                            st_next.dash = 1'b1;
                        end
                    end
                    else if (ch inside {[CH_0:CH_9]})
                    begin
                        if (st.dash)
                        begin
                            if (st.error == ERR_NONE) st_next.error = ERR_CLOCK;
                        end
                        else if (st.field_index == FIELD_HALF)
                        begin
                            half_next = clk_upd;
                        end
                        else
                        begin
                            full_next = clk_upd;
                        end
                    end
                    else if (st.error == ERR_NONE)
                    begin
                        st_next.error = ERR_CLOCK;
                    end
                end
                default:
                begin
                    st_next.error = st.error;
                end
            endcase
            if (st.token_len < LEN_SAT)
            begin
                st_next.token_len = st.token_len + 3'd1;
            end
        end

        // Close out the string and emit the summary
        if (last)
        begin
            if (st_next.token_len != 3'd0)
            begin
                st_next = finish_token(st_next);
            end
            if (st_next.field_index < FIELD_EP)
            begin
                final_err = ERR_MISSING;
            end
            else if (st_next.row_count != LAST_ROW)
            begin
                final_err = ERR_RANKS;
            end
            else
            begin
                final_err = st_next.error;
            end
            emit           = 1'b1;
            res            = '0;
            res.kind       = KIND_SUMMARY;
            res.side       = st_next.side;
            res.castling   = st_next.castle;
            res.ep_valid   = st_next.ep[6];
            res.ep_square  = st_next.ep[6] ? st_next.ep[5:0] : 6'd0;
            res.halfmove   = half16;
            res.fullmove   = full16;
            res.error_code = final_err;
            st_next        = '0;
            half_next      = '0;
            full_next      = '0;
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import fpp_pkg::*;

    localparam int unsigned RANDOM_CHARS = 900;
    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CLOCK_SAT    = 32'd65535;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } fen_beat_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;

    fen_beat_t    char_queue[$];
    result_t      expected_results[$];
    byte unsigned text[$];
    string        piece_letters = "PNBRQKpnbrqk";

    logic        in_taken     = 1'b0;
    int unsigned sent_count   = 0;
    int unsigned total_chars  = 0;
    int unsigned idle_cycles  = 0;
    int unsigned mismatches   = 0;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;

    // Position state mirrored from the character stream
    logic [2:0]  fen_field;
    logic [3:0]  slash_count;
    logic [3:0]  next_file;
    logic [2:0]  tok_len;
    logic        to_move;
    logic [3:0]  rights;
    logic [6:0]  ep_state;     // bit 6 valid, low bits square or pending file
    logic [15:0] half_clk;
    logic [15:0] full_clk;
    logic [3:0]  first_err;
    logic        tok_dash;

    fen_position_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // Idle mix per third of the stream: sender light, then receiver light, then none
    assign src_idle_pct  = (3 * sent_count < total_chars) ? 19 :
                           (3 * sent_count < 2 * total_chars) ? 46 : 0;
    assign sink_idle_pct = (3 * sent_count < total_chars) ? 46 :
                           (3 * sent_count < 2 * total_chars) ? 19 : 0;

    task automatic clear_position();
        fen_field   = FIELD_PLACE;
        slash_count = 4'd0;
        next_file   = 4'd0;
        tok_len     = 3'd0;
        to_move     = 1'b0;
        rights      = 4'd0;
        ep_state    = 7'd0;
        half_clk    = 16'd0;
        full_clk    = 16'd0;
        first_err   = ERR_NONE;
        tok_dash    = 1'b0;
    endtask

    // Keep only the first error seen in the stream
    task automatic flag_error(input logic [3:0] code);
        if (first_err == ERR_NONE)
        begin
            first_err = code;
        end
    endtask

    task automatic close_token();
        if (fen_field == FIELD_EP && tok_len == 3'd1 && !tok_dash)
        begin
            flag_error(ERR_EP);
        end
        tok_len  = 3'd0;
        tok_dash = 1'b0;
        if (fen_field < FIELD_EXTRA)
        begin
            fen_field = fen_field + 3'd1;
        end
    endtask

    // Append a decimal digit to a move counter, saturating
    function automatic logic [15:0] clock_step(input logic [15:0] v, input logic [7:0] c);
        int unsigned n;
        n = 32'(v) * 10 + 32'(c - CH_0);
        return (n > CLOCK_SAT) ? 16'hFFFF : n[15:0];
    endfunction

    // Advance the position state by one character and queue what it yields
    task automatic parse_char(input logic [7:0] c, input logic fin);
        result_t    r;
        logic       upper;
        logic [7:0] lc;
        logic       known;
        logic [2:0] pk;
        logic [4:0] reach;
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
        begin
            if (tok_len != 3'd0)
            begin
                close_token();
            end
        end
        else
        begin
            case (fen_field)
                FIELD_PLACE:
                begin
                    if (c == CH_SLASH)
                    begin
                        if (slash_count != ROW_SAT)
                        begin
                            slash_count = slash_count + 4'd1;
                        end
                        next_file = 4'd0;
                    end
                    else if (c >= CH_0 && c <= CH_9)
                    begin
                        reach = {1'b0, next_file} + 5'(c - CH_0);
                        if (reach > 5'(FILE_LIM))
                        begin
                            flag_error(ERR_WIDE);
                        end
                        else
                        begin
                            next_file = reach[3:0];
                        end
                    end
                    else
                    begin
                        upper = (c >= CH_UA && c <= CH_UZ);
                        lc    = upper ? c + CASE_OFS : c;
                        known = 1'b1;
                        pk    = PIECE_PAWN;
                        case (lc)
                            CH_P:    pk = PIECE_PAWN;
                            CH_N:    pk = PIECE_KNIGHT;
                            CH_B:    pk = PIECE_BISHOP;
                            CH_R:    pk = PIECE_ROOK;
                            CH_Q:    pk = PIECE_QUEEN;
                            CH_K:    pk = PIECE_KING;
                            default: known = 1'b0;
                        endcase
                        if (!known)
                        begin
                            flag_error(ERR_PIECE);
                        end
                        else if (next_file >= FILE_LIM)
                        begin
                            flag_error(ERR_WIDE);
                        end
                        else
                        begin
                            // Rows past the eighth and a piece on the final character place nothing
                            if (slash_count < ROW_LIM && !fin)
                            begin
                                r = '0;
                                r.kind         = KIND_PLACE;
                                r.square_index = {3'(LAST_ROW - slash_count), next_file[2:0]};
                                r.color        = !upper;
                                r.piece_kind   = pk;
                                expected_results.push_back(r);
                            end
                            next_file = next_file + 4'd1;
                        end
                    end
                end
                FIELD_SIDE:
                begin
                    if (tok_len == 3'd0 && c == CH_W)
                    begin
                        to_move = 1'b0;
                    end
                    else if (tok_len == 3'd0 && c == CH_B)
                    begin
                        to_move = 1'b1;
                    end
                    else
                    begin
                        flag_error(ERR_SIDE);
                    end
                end
                FIELD_CASTLE:
                begin
                    if (c == CH_DASH)
                    begin
                        if (tok_len != 3'd0)
                        begin
                            flag_error(ERR_CASTLE);
                        end
                        else
                        begin
                            tok_dash = 1'b1;
                        end
                    end
                    else if (c == CH_UK || c == CH_UQ || c == CH_K || c == CH_Q)
                    begin
                        if (tok_dash)
                        begin
                            flag_error(ERR_CASTLE);
                        end
                        else if (c == CH_UK)
                        begin
                            rights[0] = 1'b1;
                        end
                        else if (c == CH_UQ)
                        begin
                            rights[1] = 1'b1;
                        end
                        else if (c == CH_K)
                        begin
                            rights[2] = 1'b1;
                        end
                        else
                        begin
                            rights[3] = 1'b1;
                        end
                    end
                    else
                    begin
                        flag_error(ERR_CASTLE);
                    end
                end
                FIELD_EP:
                begin
                    if (tok_len == 3'd0)
                    begin
                        if (c == CH_DASH)
                        begin
                            tok_dash = 1'b1;
                        end
                        else if (c >= CH_A && c <= CH_H)
                        begin
                            ep_state = 7'(c - CH_A);
                        end
                        else
                        begin
                            flag_error(ERR_EP);
                        end
                    end
                    else if (tok_len == 3'd1 && !tok_dash && c >= CH_1 && c <= CH_8)
                    begin
                        ep_state = {1'b1, 3'(c - CH_1), ep_state[2:0]};
                    end
                    else
                    begin
                        flag_error(ERR_EP);
                    end
                end
                FIELD_HALF, FIELD_FULL:
                begin
                    if (c == CH_DASH)
                    begin
                        if (tok_len != 3'd0)
                        begin
                            flag_error(ERR_CLOCK);
                        end
                        else
                        begin
                            tok_dash = 1'b1;
                        end
                    end
                    else if (c >= CH_0 && c <= CH_9)
                    begin
                        if (tok_dash)
                        begin
                            flag_error(ERR_CLOCK);
                        end
                        else if (fen_field == FIELD_HALF)
                        begin
                            half_clk = clock_step(half_clk, c);
                        end
                        else
                        begin
                            full_clk = clock_step(full_clk, c);
                        end
                    end
                    else
                    begin
                        flag_error(ERR_CLOCK);
                    end
                end
                default:
                begin
                end
            endcase
            if (tok_len != LEN_SAT)
            begin
                tok_len = tok_len + 3'd1;
            end
        end

        // Close the string with a summary and start over
        if (fin)
        begin
            if (tok_len != 3'd0)
            begin
                close_token();
            end
            r = '0;
            r.kind      = KIND_SUMMARY;
            r.side      = to_move;
            r.castling  = rights;
            r.ep_valid  = ep_state[6];
            r.ep_square = ep_state[6] ? ep_state[5:0] : 6'd0;
            r.halfmove  = half_clk;
            r.fullmove  = full_clk;
            if (fen_field < FIELD_EP)
            begin
                r.error_code = ERR_MISSING;
            end
            else if (slash_count != LAST_ROW)
            begin
                r.error_code = ERR_RANKS;
            end
            else
            begin
                r.error_code = first_err;
            end
            expected_results.push_back(r);
            clear_position();
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
        if (want !== seen)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
            mismatches++;
        end
    endtask

    // Turn the text under construction into beats, tlast on its final character
    task automatic emit_text();
        foreach (text[i])
        begin
            char_queue.push_back('{ch: text[i], last: (i == text.size() - 1)});
        end
        text.delete();
    endtask

    task automatic add_gap();
        repeat ($urandom_range(1, 3))
        begin
            text.push_back(($urandom_range(3) == 0) ? 8'(CH_TAB + $urandom_range(4)) : CH_SPACE);
        end
    endtask

    task automatic add_clock();
        int sel;
        sel = $urandom_range(19);
        if (sel == 0)
        begin
            text.push_back(CH_DASH);
        end
        else if (sel == 1)
        begin
            text.push_back(CH_DASH);
            text.push_back(8'(CH_0 + $urandom_range(9)));
        end
        else if (sel == 2)
        begin
            text.push_back(8'(CH_0 + $urandom_range(9)));
            text.push_back(8'($urandom_range(CH_UA, CH_UZ)));
        end
        else
        begin
            // Long runs drive the counter into saturation
            repeat ((sel < 5) ? $urandom_range(5, 9) : $urandom_range(1, 3))
            begin
                text.push_back(8'(CH_0 + $urandom_range(9)));
            end
        end
    endtask

    // Send characters: fill on the falling edge, hold until taken
    always @(negedge clk)
    begin
        fen_beat_t nb;
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (char_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    nb = char_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nb.ch;
                    s_tlast  <= nb.last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Predict on each accepted character, check each accepted result, watch for a hang
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                parse_char(s_tdata, s_tlast);
                sent_count <= sent_count + 1;
            end
            if (m_tvalid && m_tready)
            begin
                got              = '0;
                got.kind         = m_tuser;
                got.square_index = m_tdata[5:0];
                got.color        = m_tdata[6];
                got.piece_kind   = m_tdata[9:7];
                got.side         = m_tdata[10];
                got.castling     = m_tdata[14:11];
                got.ep_valid     = m_tdata[15];
                got.ep_square    = m_tdata[21:16];
                got.halfmove     = m_tdata[37:22];
                got.fullmove     = m_tdata[53:38];
                got.error_code   = m_tdata[57:54];
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual kind %0d data %h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("square_index", want.square_index, got.square_index);
                    check_field("color", want.color, got.color);
                    check_field("piece_kind", want.piece_kind, got.piece_kind);
                    check_field("side", want.side, got.side);
                    check_field("castling", want.castling, got.castling);
                    check_field("ep_valid", want.ep_valid, got.ep_valid);
                    check_field("ep_square", want.ep_square, got.ep_square);
                    check_field("halfmove", want.halfmove, got.halfmove);
                    check_field("fullmove", want.fullmove, got.fullmove);
                    check_field("error_code", want.error_code, got.error_code);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
                $display("tb: FAIL");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        int    rows;
        int    f;
        int    d;
        int    fields;
        int    sel;
        string fixed_fen;

        clear_position();

        // Piece on the final character: too few tokens, summary only
        text.push_back(CH_P);
        emit_text();
        // All-ones and all-zero characters
        text.push_back(8'hFF);
        emit_text();
        text.push_back(8'h00);
        emit_text();
        // Corner squares, black to move, partial castling, en passant on h1
        fixed_fen = "R7/8/8/8/8/8/8/7k\tb Kq h1";
        foreach (fixed_fen[i])
        begin
            text.push_back(fixed_fen[i]);
        end
        emit_text();

        // Mostly well-formed positions with random content and sparse damage
        while (char_queue.size() < RANDOM_CHARS + 27)
        begin
            if ($urandom_range(11) == 0)
            begin
                repeat ($urandom_range(1, 12))
                begin
                    text.push_back(8'($urandom()));
                end
                emit_text();
            end
            else
            begin
                if ($urandom_range(9) == 0)
                begin
                    add_gap();
                end
                rows = ($urandom_range(9) == 0) ? $urandom_range(1, 17) : 8;
                for (int r = 0; r < rows; r++)
                begin
                    if (r > 0)
                    begin
                        text.push_back(CH_SLASH);
                    end
                    f = 0;
                    while (f < 8)
                    begin
                        if ($urandom_range(99) < 30)
                        begin
                            d = $urandom_range(1, 8 - f);
                            text.push_back(8'(CH_0 + d));
                            f += d;
                        end
                        else
                        begin
                            text.push_back(piece_letters[$urandom_range(11)]);
                            f++;
                        end
                    end
                    // Damage the row now and then
                    case ($urandom_range(39))
                        0: text.push_back(piece_letters[$urandom_range(11)]);
                        1: text.push_back(8'(CH_0 + $urandom_range(1, 9)));
                        2: text.push_back(8'($urandom()));
                        3: text.push_back(CH_0);
                        default:
                        begin
                        end
                    endcase
                end

                fields = ($urandom_range(9) < 7) ? 5 : $urandom_range(7);
                if (fields >= 1)
                begin
                    add_gap();
                    sel = $urandom_range(19);
                    if (sel == 0)
                    begin
                        text.push_back(8'($urandom()));
                    end
                    else if (sel == 1)
                    begin
                        text.push_back(CH_W);
                        text.push_back(CH_B);
                    end
                    else
                    begin
                        text.push_back($urandom_range(1) ? CH_W : CH_B);
                    end
                end
                if (fields >= 2)
                begin
                    add_gap();
                    if ($urandom_range(99) < 15)
                    begin
                        text.push_back(CH_DASH);
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 4))
                        begin
                            case ($urandom_range(3))
                                0:       text.push_back(CH_UK);
                                1:       text.push_back(CH_UQ);
                                2:       text.push_back(CH_K);
                                default: text.push_back(CH_Q);
                            endcase
                        end
                    end
                    if ($urandom_range(9) == 0)
                    begin
                        text.push_back($urandom_range(1) ? CH_DASH : 8'($urandom()));
                    end
                end
                if (fields >= 3)
                begin
                    add_gap();
                    sel = $urandom_range(99);
                    if (sel < 40)
                    begin
                        text.push_back(CH_DASH);
                    end
                    else if (sel < 85)
                    begin
                        text.push_back(8'(CH_A + $urandom_range(7)));
                        text.push_back(8'(CH_1 + $urandom_range(7)));
                    end
                    else
                    begin
                        case ($urandom_range(4))
                            0: text.push_back(8'(CH_A + $urandom_range(7)));
                            1:
                            begin
                                text.push_back(8'(CH_A + $urandom_range(7)));
                                text.push_back(CH_9);
                            end
                            2:
                            begin
                                text.push_back(CH_DASH);
                                text.push_back(8'(CH_A + $urandom_range(7)));
                            end
                            3: text.push_back(8'($urandom()));
                            default:
                            begin
                                text.push_back(8'(CH_A + $urandom_range(7)));
                                text.push_back(8'(CH_1 + $urandom_range(7)));
                                text.push_back(8'(CH_1 + $urandom_range(7)));
                            end
                        endcase
                    end
                end
                if (fields >= 4)
                begin
                    add_gap();
                    add_clock();
                end
                if (fields >= 5)
                begin
                    add_gap();
                    add_clock();
                end
                // Trailing tokens past the move number
                for (int k = 5; k < fields; k++)
                begin
                    add_gap();
                    repeat ($urandom_range(1, 3))
                    begin
                        text.push_back(8'($urandom_range(CH_0, CH_UZ)));
                    end
                end
                if ($urandom_range(9) == 0)
                begin
                    add_gap();
                end
                emit_text();
            end
        end
        total_chars = char_queue.size();

        // Hold reset, release away from the sampling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: all beats sent, every result back, then a quiet drain period
        while (char_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
